// ===== design/lsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lsr_pkg;

    localparam int VAL_W      = 32;
    localparam int IDX_IN_W   = 4;
    localparam int ORDER_W    = 5;
    localparam int S_TDATA_W  = 40;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 40;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int FRAC_W     = 16;

    typedef enum logic [1:0] {
        REQ_MAT  = 2'd0,
        REQ_ROOT = 2'd1,
        REQ_RHS  = 2'd2,
        REQ_CALC = 2'd3
    } t_req;

    typedef enum logic [0:0] {
        REG_ORDER = 1'b0,
        REG_NONE  = 1'b1
    } t_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

// ===== design/lsr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/linear_system_residual_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  | dir | handshake                   | payload
// s_axis   | in  | tvalid/tready               | tuser: req_type; tdata: row, col, value
// m_axis   | out | tvalid/tready               | tdata: index, residual; tlast: last
// apb      | in  | psel/penable/pwrite, pready | order at byte 0
//
// Load items are accepted while idle. A compute item holds s_axis_tready low until
// its last row is emitted (n = order): per row, n products go through the shared
// 32x32 multiplier and accumulator, the pipeline drains, and the row is emitted.
// Reset is synchronous; it clears control and sets order to 1, stores are not cleared.
// m_axis has an output register; a stalled sink holds the sequencer in emit.

module linear_system_residual_top
    import lsr_pkg::*;
#(
    parameter int MAX_ORDER = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // row[3:0], col[7:4], value[39:8]
    input  wire logic [S_TUSER_W-1:0] s_axis_tuser,  // req_type[1:0]
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [M_TDATA_W-1:0] m_axis_tdata,  // index[3:0], residual[35:4], zero[39:36]
    output logic                      m_axis_tlast,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [PDATA_W-1:0]   pwdata,
    output logic      [PDATA_W-1:0]   prdata,
    output logic                      pready
);

    localparam int IDX_W = $clog2(MAX_ORDER);
    localparam int MAW   = $clog2(MAX_ORDER * MAX_ORDER);
    localparam int CMP_W = ((IDX_W > ORDER_W) ? IDX_W : ORDER_W) + 1;
    localparam int ACC_W = 66 + IDX_W;
    localparam int SAT_LO = VAL_W + FRAC_W - 1;

    t_state r_state, n_state;
    logic [ORDER_W-1:0] r_order;
    logic [IDX_W-1:0] r_i, n_i, r_j, n_j;

    logic issue, emit_load, last_j, last_i, slot_free;

    logic in_fire;
    t_req in_req;
    logic [IDX_IN_W-1:0] in_row, in_col;
    logic [VAL_W-1:0] in_val;
    logic row_ok, col_ok;
    logic mat_we, root_we, rhs_we;

    logic [MAW-1:0] mat_waddr, mat_raddr;
    logic [VAL_W-1:0] mat_q, root_q, rhs_q;

    logic r_v1, r_first1, r_last1;
    logic r_v2, r_first2, r_last2;
    logic signed [2*VAL_W-1:0] r_prod;
    logic [VAL_W-1:0] r_rhs2;
    logic signed [VAL_W+FRAC_W-1:0] acc_init48;
    logic signed [ACC_W-1:0] r_acc, acc_base;

    logic [ACC_W-SAT_LO-1:0] acc_hi;
    logic [VAL_W-1:0] sat_res;

    logic r_out_valid, n_out_valid;
    logic [IDX_IN_W-1:0] r_out_index;
    logic [VAL_W-1:0] r_out_res;
    logic r_out_last;

    logic cfg_we;
    logic [ORDER_W-1:0] wr_order;

    // input decode
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign in_req  = t_req'(s_axis_tuser);
    assign in_row  = s_axis_tdata[3:0];
    assign in_col  = s_axis_tdata[7:4];
    assign in_val  = s_axis_tdata[39:8];
    assign row_ok  = ({28'd0, in_row} < MAX_ORDER);
    assign col_ok  = ({28'd0, in_col} < MAX_ORDER);

    always_comb begin
        mat_we  = 1'b0;
        root_we = 1'b0;
        rhs_we  = 1'b0;
        unique case (in_req)
            REQ_MAT:  mat_we  = in_fire && row_ok && col_ok;
            REQ_ROOT: root_we = in_fire && row_ok;
            REQ_RHS:  rhs_we  = in_fire && row_ok;
            REQ_CALC: ;
            default:  ;
        endcase
    end

    assign mat_waddr = MAW'(MAW'(IDX_W'(in_row)) * MAW'(MAX_ORDER) + MAW'(IDX_W'(in_col)));
    assign mat_raddr = MAW'(MAW'(r_i) * MAW'(MAX_ORDER) + MAW'(r_j));

    lsr_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ORDER * MAX_ORDER)) u_mat (
        .i_clk   (i_clk),
        .i_we    (mat_we),
        .i_waddr (mat_waddr),
        .i_wdata (in_val),
        .i_raddr (mat_raddr),
        .o_rdata (mat_q)
    );

    lsr_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ORDER)) u_root (
        .i_clk   (i_clk),
        .i_we    (root_we),
        .i_waddr (IDX_W'(in_row)),
        .i_wdata (in_val),
        .i_raddr (r_j),
        .o_rdata (root_q)
    );

    lsr_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ORDER)) u_rhs (
        .i_clk   (i_clk),
        .i_we    (rhs_we),
        .i_waddr (IDX_W'(in_row)),
        .i_wdata (in_val),
        .i_raddr (r_i),
        .o_rdata (rhs_q)
    );

    // sequencer
    assign last_j    = (CMP_W'(r_j) + CMP_W'(1)) == CMP_W'(r_order);
    assign last_i    = (CMP_W'(r_i) + CMP_W'(1)) == CMP_W'(r_order);
    assign slot_free = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        issue     = 1'b0;
        emit_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && in_req == REQ_CALC) begin
                    n_state = S_ISSUE;
                    n_i     = '0;
                    n_j     = '0;
                end
            end
            S_ISSUE: begin
                issue = 1'b1;
                if (last_j) begin
                    n_state = S_DRAIN;
                    n_j     = '0;
                end else begin
                    n_j = r_j + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                if (r_v2 && r_last2) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    emit_load = 1'b1;
                    if (last_i) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + IDX_W'(1);
                        n_state = S_ISSUE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    // multiply-accumulate pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
        end
    end

    assign acc_init48 = {r_rhs2, 16'h8000};   // b in Q16.32 plus the rounding half
    assign acc_base   = r_first2 ? ACC_W'(acc_init48) : r_acc;

    always_ff @(posedge i_clk) begin
        r_first1 <= (r_j == '0);
        r_last1  <= last_j;
        r_first2 <= r_first1;
        r_last2  <= r_last1;
        r_prod   <= $signed(mat_q) * $signed(root_q);
        r_rhs2   <= rhs_q;
        if (r_v2) begin
            r_acc <= acc_base - ACC_W'(r_prod);
        end
    end

    // round already folded in; saturate to Q16.16
    assign acc_hi = r_acc[ACC_W-1:SAT_LO];
    always_comb begin
        if (acc_hi == '0 || acc_hi == '1) begin
            sat_res = r_acc[SAT_LO:FRAC_W];
        end else if (r_acc[ACC_W-1]) begin
            sat_res = 32'h8000_0000;
        end else begin
            sat_res = 32'h7FFF_FFFF;
        end
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        if (emit_load) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        if (emit_load) begin
            r_out_index <= IDX_IN_W'(r_i);
            r_out_res   <= sat_res;
            r_out_last  <= last_i;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_res, r_out_index};
    assign m_axis_tlast  = r_out_last;

    // configuration
    assign pready   = 1'b1;
    assign cfg_we   = psel && penable && pwrite && pready && (t_reg'(paddr[2]) == REG_ORDER);

    always_comb begin
        if (pwdata[4:0] == '0) begin
            wr_order = ORDER_W'(1);
        end else if ({27'd0, pwdata[4:0]} > MAX_ORDER) begin
            wr_order = ORDER_W'(MAX_ORDER);
        end else begin
            wr_order = pwdata[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_W'(1);
        end else if (cfg_we) begin
            r_order <= wr_order;
        end
    end

    always_comb begin
        unique case (t_reg'(paddr[2]))
            REG_ORDER: prdata = {27'd0, r_order};
            REG_NONE:  prdata = '0;
            default:   prdata = '0;
        endcase
    end

    // checks
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_v1 && !r_v2))
        else $error("pipeline busy while idle");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !(mat_we || root_we || rhs_we))
        else $error("store written during compute");

    a_emit_after_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_EMIT) |-> $past(r_v2 && r_last2))
        else $error("emit before row finished");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (r_out_index == IDX_IN_W'(r_order - ORDER_W'(1))))
        else $error("last item index mismatch");

endmodule

`default_nettype wire

// ===== sim/linear_system_residual_top_tb.sv =====
`timescale 1ns / 1ps

module linear_system_residual_top_tb;
    import lsr_pkg::*;

    localparam int N_MAX      = 16;
    localparam int SINK_HOLD  = 400;
    localparam int STALL_MAX  = 5000;
    localparam int SETTLE     = 8;
    localparam int RAND_ITEMS = 450;

    typedef struct packed {
        logic [3:0]  idx;
        logic [31:0] value;
        logic        last;
    } t_resid;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // row[3:0], col[7:4], value[39:8]
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;   // req_type[1:0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // index[3:0], residual[35:4], zero[39:36]
    logic                 m_axis_tlast;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // mirror of the block's stores and order
    logic signed [31:0] a_mem [N_MAX][N_MAX];
    logic signed [31:0] x_mem [N_MAX];
    logic signed [31:0] b_mem [N_MAX];
    bit                 a_set [N_MAX][N_MAX];
    bit                 x_set [N_MAX];
    bit                 b_set [N_MAX];
    int                 order_n = 1;

    t_resid pending_resid [$];
    int     err_cnt   = 0;
    int     items_sent = 0;
    int     stall_cnt = 0;
    bit     no_idle   = 1'b0;
    bit     hold_sink = 1'b0;

    linear_system_residual_top #(
        .MAX_ORDER(N_MAX)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // b[r] - sum_c A[r][c]*x[c], exact, rounded half up, saturated to Q16.16
    function automatic logic [31:0] row_residual(int r);
        logic signed [79:0] acc;
        logic signed [79:0] shifted;
        acc = b_mem[r];
        acc = acc <<< FRAC_W;
        for (int c = 0; c < order_n; c++) begin
            acc = acc - a_mem[r][c] * x_mem[c];
        end
        acc = acc + 80'sd32768;
        shifted = acc >>> FRAC_W;
        if (shifted > 80'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (shifted < -80'sd2147483648) begin
            return 32'h8000_0000;
        end
        return shifted[31:0];
    endfunction

    function automatic logic [31:0] draw_value();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h0001_0000;
                endcase
            end
            1: return $urandom();
            default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch: %s", msg);
        err_cnt++;
    endtask

    task automatic send_item(t_req kind, logic [3:0] r, logic [3:0] c, logic [31:0] v);
        int gap;
        t_resid exp_item;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {v, c, r};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        case (kind)
            REQ_MAT: begin
                a_mem[r][c] = v;
                a_set[r][c] = 1'b1;
            end
            REQ_ROOT: begin
                x_mem[r] = v;
                x_set[r] = 1'b1;
            end
            REQ_RHS: begin
                b_mem[r] = v;
                b_set[r] = 1'b1;
            end
            default: begin
                for (int i = 0; i < order_n; i++) begin
                    exp_item = {4'(i), row_residual(i), i == order_n - 1};
                    pending_resid.insert(pending_resid.size(), exp_item);
                end
            end
        endcase
    endtask

    task automatic send_calc();
        send_item(REQ_CALC, 4'($urandom()), 4'($urandom()), $urandom());
    endtask

    // load every entry a compute of order n reads that is still unwritten
    task automatic ensure_loaded(int n);
        for (int r = 0; r < n; r++) begin
            if (!b_set[r]) send_item(REQ_RHS, 4'(r), 4'($urandom()), draw_value());
            if (!x_set[r]) send_item(REQ_ROOT, 4'(r), 4'($urandom()), draw_value());
            for (int c = 0; c < n; c++) begin
                if (!a_set[r][c]) send_item(REQ_MAT, 4'(r), 4'(c), draw_value());
            end
        end
    endtask

    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        while (pending_resid.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_write(t_reg which, logic [31:0] data);
        int v;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {which, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (which == REG_ORDER) begin
            v = int'(data[ORDER_W-1:0]);
            order_n = (v == 0) ? 1 : (v > N_MAX) ? N_MAX : v;
        end
        @(posedge i_clk);
    endtask

    task automatic test_basic_loads();
        send_item(REQ_MAT, 4'd0, 4'd0, 32'h0001_0000);
        send_item(REQ_ROOT, 4'd0, 4'd15, 32'h0002_0000);
        send_item(REQ_RHS, 4'd0, 4'd9, 32'h0003_0000);
        send_calc();
        send_item(REQ_MAT, 4'd15, 4'd15, 32'h8000_0000);
        send_item(REQ_ROOT, 4'd15, 4'd0, 32'h7FFF_FFFF);
        send_item(REQ_RHS, 4'd15, 4'd15, 32'hFFFF_FFFF);
    endtask

    task automatic test_saturation();
        send_item(REQ_MAT, 4'd0, 4'd0, 32'h7FFF_FFFF);
        send_item(REQ_ROOT, 4'd0, 4'd0, 32'h7FFF_FFFF);
        send_item(REQ_RHS, 4'd0, 4'd0, 32'h8000_0000);
        send_calc();
        send_item(REQ_MAT, 4'd0, 4'd0, 32'h8000_0000);
        send_calc();
        // exact upper bound, no clipping
        send_item(REQ_MAT, 4'd0, 4'd0, 32'h0001_0000);
        send_item(REQ_ROOT, 4'd0, 4'd0, 32'h8000_0000);
        send_item(REQ_RHS, 4'd0, 4'd0, 32'hFFFF_FFFF);
        send_calc();
    endtask

    task automatic test_rounding_ties();
        send_item(REQ_MAT, 4'd0, 4'd0, 32'h0000_0001);
        send_item(REQ_ROOT, 4'd0, 4'd0, 32'h0000_8000);
        send_item(REQ_RHS, 4'd0, 4'd0, 32'h0000_0000);
        send_calc();
        send_item(REQ_MAT, 4'd0, 4'd0, 32'hFFFF_FFFF);
        send_calc();
    endtask

    task automatic test_order_config();
        wait_results_done();
        apb_write(REG_ORDER, 32'd0);
        send_calc();
        wait_results_done();
        apb_write(REG_NONE, 32'd5);
        send_calc();
        wait_results_done();
        apb_write(REG_ORDER, 32'd2);
        ensure_loaded(order_n);
        send_calc();
    endtask

    task automatic test_random_mix();
        int cfg;
        t_reg which;
        while (items_sent < RAND_ITEMS) begin
            wait_results_done();
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0) cfg = $urandom_range(16, 31);
            else cfg = $urandom_range(0, 8);
            which = ($urandom_range(0, 5) == 0) ? REG_NONE : REG_ORDER;
            apb_write(which, {27'($urandom()), 5'(cfg)});
            repeat ($urandom_range(2, 6)) begin
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 4)) begin
                        send_item(t_req'($urandom_range(0, 2)), 4'($urandom()),
                                  4'($urandom()), draw_value());
                    end
                end else begin
                    ensure_loaded(order_n);
                    repeat ($urandom_range(0, 4)) begin
                        send_item(t_req'($urandom_range(0, 2)),
                                  4'($urandom_range(0, order_n - 1)),
                                  4'($urandom_range(0, order_n - 1)), draw_value());
                    end
                    send_calc();
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // sink stalls long while the sender keeps offering items
    task automatic test_sink_hold();
        wait_results_done();
        apb_write(REG_ORDER, 32'd6);
        ensure_loaded(order_n);
        hold_sink = 1'b1;
        send_calc();
        repeat (3) send_item(REQ_MAT, 4'($urandom_range(0, 5)), 4'($urandom_range(0, 5)),
                             draw_value());
        send_calc();
        send_item(REQ_ROOT, 4'd2, 4'($urandom()), draw_value());
        send_calc();
    endtask

    task automatic test_drain_pause();
        send_calc();
        wait_results_done();
        send_item(REQ_RHS, 4'd1, 4'($urandom()), draw_value());
        send_calc();
    endtask

    task automatic test_order_max();
        wait_results_done();
        apb_write(REG_ORDER, 32'd31);
        ensure_loaded(order_n);
        send_calc();
        wait_results_done();
        apb_write(REG_ORDER, 32'd16);
        send_calc();
        wait_results_done();
        apb_write(REG_ORDER, 32'd17);
        send_calc();
    endtask

    // result sink
    initial begin : sink_proc
        int wait_n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_sink) begin
                wait_n = SINK_HOLD;
                hold_sink = 1'b0;
            end else begin
                wait_n = no_idle ? 0 : $urandom_range(0, 13);
            end
            if (wait_n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin : residual_check
        t_resid want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_resid.size() == 0) begin
                report_mismatch($sformatf("unexpected residual idx=%0d val=%h",
                                          m_axis_tdata[3:0], m_axis_tdata[35:4]));
            end else begin
                want = pending_resid.pop_front();
                if (m_axis_tdata[3:0] !== want.idx)
                    report_mismatch($sformatf("index got %0d want %0d",
                                              m_axis_tdata[3:0], want.idx));
                if (m_axis_tdata[35:4] !== want.value)
                    report_mismatch($sformatf("residual idx %0d got %h want %h",
                                              want.idx, m_axis_tdata[35:4], want.value));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("last idx %0d got %b want %b",
                                              want.idx, m_axis_tlast, want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
        if (stall_cnt == STALL_MAX) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_loads();
        test_saturation();
        test_rounding_ties();
        test_order_config();
        test_random_mix();
        test_sink_hold();
        test_drain_pause();
        test_order_max();
        s_axis_tvalid <= 1'b0;
        while (pending_resid.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== linear_system_residual_top.f =====
design/lsr_pkg.sv
design/lsr_ram.sv
design/linear_system_residual_top.sv
sim/linear_system_residual_top_tb.sv
